// File: sv/rbh_pkg.sv
package rbh_pkg;

  // Field widths.
  localparam int ELEV_W   = 18;
  localparam int RANGE_W  = 20;
  localparam int HEIGHT_W = 21;
  localparam int GROUND_W = 20;
  localparam int RADIUS_W = 24;

  // Datapath widths: x/y of the rotation (Q16 m), rotation angle (Q30),
  // u/v of the vectoring (Q16 m) and the accumulated ground angle (Q30).
  localparam int XW  = 38;
  localparam int ZRW = 34;
  localparam int UW  = 43;
  localparam int ZVW = 33;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd8494667;
  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30  = 32'd1686629713;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

  typedef struct packed {
    logic signed [XW-1:0]  x;
    logic signed [XW-1:0]  y;
    logic signed [ZRW-1:0] z;
    logic                  flip;
  } rot_t;

  typedef struct packed {
    logic signed [UW-1:0]  u;
    logic signed [UW-1:0]  v;
    logic signed [ZVW-1:0] z;
    logic                  zero;
  } vec_t;

  // Arctangent of 2^-i in Q30 radians.
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      5'd30: r = 32'h00000001;
      5'd31: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// File: sv/rbh_if.sv
interface rbh_in_if import rbh_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ELEV_W-1:0]  elevation;
  logic        [RANGE_W-1:0] beam_range;

  modport source(output valid, elevation, beam_range, input ready);
  modport sink(input valid, elevation, beam_range, output ready);
endinterface

interface rbh_out_if import rbh_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [HEIGHT_W-1:0] height;
  logic        [GROUND_W-1:0] ground_distance;

  modport source(output valid, height, ground_distance, input ready);
  modport sink(input valid, height, ground_distance, output ready);
endinterface

// File: sv/rbh_fold_stage.sv
module rbh_fold_stage import rbh_pkg::*; #(
  parameter int QW  = 33,
  parameter int BIT = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [QW-1:0]        in_q,
  input  logic                 in_neg,
  input  logic                 in_flip,
  input  logic signed [XW-1:0] in_x,
  output logic                 out_valid,
  output logic [QW-1:0]        out_q,
  output logic                 out_neg,
  output logic                 out_flip,
  output logic signed [XW-1:0] out_x
);

  // One restoring-division step by pi; only the parity of the quotient matters.
  localparam logic [QW-1:0] STEP = QW'(PI_Q30) << BIT;

  logic take;
  assign take = (in_q >= STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      out_q    <= take ? in_q - STEP : in_q;
      out_flip <= in_flip ^ (take & (BIT == 0));
      out_neg  <= in_neg;
      out_x    <= in_x;
    end
  end

endmodule

// File: sv/rbh_rot_stage.sv
module rbh_rot_stage import rbh_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  rot_t in_d,
  output logic out_valid,
  output rot_t out_d
);

  localparam logic signed [ZRW-1:0] ANG = ZRW'(atan_q30(5'(IDX)));

  logic signed [XW-1:0]  x, y, dx, dy;
  logic signed [ZRW-1:0] z;
  rot_t d_next;

  always_comb begin
    x  = in_d.x;
    y  = in_d.y;
    z  = in_d.z;
    dx = y >>> IDX;
    dy = x >>> IDX;
    d_next = in_d;
    if (z >= 0) begin
      d_next.x = x - dx;
      d_next.y = y + dy;
      d_next.z = z - ANG;
    end else begin
      d_next.x = x + dx;
      d_next.y = y - dy;
      d_next.z = z + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      out_d <= d_next;
    end
  end

endmodule

// File: sv/rbh_vec_stage.sv
module rbh_vec_stage import rbh_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  vec_t in_d,
  output logic out_valid,
  output vec_t out_d
);

  localparam logic signed [ZVW-1:0] ANG = ZVW'(atan_q30(5'(IDX)));

  logic signed [UW-1:0]  u, v, du, dv;
  logic signed [ZVW-1:0] z;
  vec_t d_next;

  always_comb begin
    u  = in_d.u;
    v  = in_d.v;
    z  = in_d.z;
    du = v >>> IDX;
    dv = u >>> IDX;
    d_next = in_d;
    if (v >= 0) begin
      d_next.u = u + du;
      d_next.v = v - dv;
      d_next.z = z + ANG;
    end else begin
      d_next.u = u - du;
      d_next.v = v + dv;
      d_next.z = z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      out_d <= d_next;
    end
  end

endmodule

// File: sv/radar_bin_height_and_ground.sv
// Radar bin height and ground distance, effective-earth-radius model.
// The input channel in_ch carries one word per radar bin: a signed elevation
// angle in radians with ANGLE_FRAC_BITS fraction bits and the on-beam range
// in metres. The output channel out_ch carries one word per bin: the height
// above ground and the ground distance, both rounded to whole metres and
// saturated. The effective radius is written through cfg_wr_en/cfg_wr_data
// and must only change while no bin is in flight.
// The block is a fully pipelined datapath. A bin can enter on every clock
// while the receiver keeps up, so the sustained rate is one word per cycle.
// A bin passes the entry register, KW angle-folding steps (1 at the default
// angle format), the rotation CORDIC, the unfold, u/v and half-plane stages,
// the vectoring CORDIC, the product register and the output register.
// Reset clears every valid bit, empties the output skid register and loads
// the radius with 4/3 of the earth radius.
// When the receiver stalls, the last result moves into a one-word skid
// register; the pipeline then freezes and in_ch.ready drops until the
// receiver takes that word, so nothing is dropped or repeated.
module radar_bin_height_and_ground import rbh_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int CORDIC_STAGES   = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [RADIUS_W-1:0] cfg_wr_data,
  rbh_in_if.sink              in_ch,
  rbh_out_if.source           out_ch
);

  // Width of the angle once scaled to Q30, and the division it needs.
  localparam int SHIFT = 30 - ANGLE_FRAC_BITS;
  localparam int ZW    = ELEV_W + SHIFT;
  localparam int QW    = ((ZW > 32) ? ZW : 32) + 1;
  localparam int KW    = (ZW > 32) ? (ZW - 31) : 1;
  localparam int NS    = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  localparam logic [QW-1:0] HALF_PI_M1 = QW'(HALF_PI_Q30) - QW'(1);

  // Effective radius register.
  logic [RADIUS_W-1:0] radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius <= cfg_wr_data;
    end
  end

  // The whole pipeline advances unless the skid register holds a word.
  logic skid_full;
  logic adv;
  assign adv         = !skid_full;
  assign in_ch.ready = !skid_full;

  // Entry stage: the folding dividend |z| + pi/2 - 1 and the prescaled range.
  // Folding z by pi into [-pi/2, pi/2] takes floor(q / pi) steps of pi, and
  // each step flips the sign of the rotated vector.
  logic [ELEV_W-1:0]          e_abs;
  logic [RANGE_W+29:0]        x_prod;
  logic                       s0_valid;
  logic [QW-1:0]              s0_q;
  logic                       s0_neg;
  logic signed [XW-1:0]       s0_x;

  always_comb begin
    e_abs  = in_ch.elevation[ELEV_W-1] ? ELEV_W'(-in_ch.elevation)
                                       : ELEV_W'(in_ch.elevation);
    x_prod = (RANGE_W+30)'(in_ch.beam_range) * (RANGE_W+30)'(INV_GAIN_Q30);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_ch.valid;
    end
    if (adv) begin
      s0_q   <= (QW'(e_abs) << SHIFT) + HALF_PI_M1;
      s0_neg <= in_ch.elevation[ELEV_W-1];
      s0_x   <= XW'((x_prod + (RANGE_W+30)'(14'h2000)) >> 14);
    end
  end

  // Folding chain: one quotient bit per stage, most significant first.
  logic                 fv    [0:KW];
  logic [QW-1:0]        fq    [0:KW];
  logic                 fneg  [0:KW];
  logic                 fflip [0:KW];
  logic signed [XW-1:0] fx    [0:KW];

  assign fv[0]    = s0_valid;
  assign fq[0]    = s0_q;
  assign fneg[0]  = s0_neg;
  assign fflip[0] = 1'b0;
  assign fx[0]    = s0_x;

  for (genvar k = 0; k < KW; k++) begin : g_fold
    rbh_fold_stage #(
      .QW (QW),
      .BIT(KW - 1 - k)
    ) u_fold (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_valid (fv[k]),
      .in_q     (fq[k]),
      .in_neg   (fneg[k]),
      .in_flip  (fflip[k]),
      .in_x     (fx[k]),
      .out_valid(fv[k+1]),
      .out_q    (fq[k+1]),
      .out_neg  (fneg[k+1]),
      .out_flip (fflip[k+1]),
      .out_x    (fx[k+1])
    );
  end

  // Folded angle: remainder minus (pi/2 - 1), with the sign of the input.
  logic                  rv [0:NS];
  rot_t                  rd [0:NS];
  logic signed [ZRW-1:0] r_abs;

  assign r_abs = $signed(ZRW'(fq[KW])) - $signed(ZRW'(HALF_PI_M1));

  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else if (adv) begin
      rv[0] <= fv[KW];
    end
    if (adv) begin
      rd[0].x    <= fx[KW];
      rd[0].y    <= '0;
      rd[0].z    <= fneg[KW] ? -r_abs : r_abs;
      rd[0].flip <= fflip[KW];
    end
  end

  // Rotation CORDIC: (b, 0) turned by the elevation gives (b cos, b sin).
  for (genvar i = 0; i < NS; i++) begin : g_rot
    rbh_rot_stage #(.IDX(i)) u_rot (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_valid (rv[i]),
      .in_d     (rd[i]),
      .out_valid(rv[i+1]),
      .out_d    (rd[i+1])
    );
  end

  // Undo the folding, then form u = a + b sin and v = b cos.
  logic                 f_valid, us_valid;
  logic signed [XW-1:0] f_x, f_y;
  logic signed [UW-1:0] us_u, us_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid  <= 1'b0;
      us_valid <= 1'b0;
    end else if (adv) begin
      f_valid  <= rv[NS];
      us_valid <= f_valid;
    end
    if (adv) begin
      f_x  <= rd[NS].flip ? -rd[NS].x : rd[NS].x;
      f_y  <= rd[NS].flip ? -rd[NS].y : rd[NS].y;
      us_u <= $signed(UW'(radius) << 16) + UW'(f_y);
      us_v <= UW'(f_x);
    end
  end

  // Move the vector into the right half plane; a zero vector has angle 0.
  logic vv [0:NS];
  vec_t vd [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vv[0] <= 1'b0;
    end else if (adv) begin
      vv[0] <= us_valid;
    end
    if (adv) begin
      vd[0].u    <= (us_u < 0) ? -us_u : us_u;
      vd[0].v    <= (us_u < 0) ? -us_v : us_v;
      vd[0].z    <= '0;
      vd[0].zero <= (us_u == '0) && (us_v == '0);
    end
  end

  // Vectoring CORDIC: magnitude and ground angle.
  for (genvar i = 0; i < NS; i++) begin : g_vec
    rbh_vec_stage #(.IDX(i)) u_vec (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_valid (vv[i]),
      .in_d     (vd[i]),
      .out_valid(vv[i+1]),
      .out_d    (vd[i+1])
    );
  end

  // Products: magnitude times 1/K (Q38) and ground angle times radius (Q30).
  logic signed [UW-9:0]  m_val;
  logic signed [ZVW-1:0] z_fin;
  logic                  mp_valid;
  logic signed [65:0]    mp_mag;
  logic signed [57:0]    mp_gnd;

  assign m_val = (UW-8)'(vd[NS].u >>> 8);
  assign z_fin = vd[NS].zero ? '0 : vd[NS].z;

  always_ff @(posedge clk) begin
    if (rst) begin
      mp_valid <= 1'b0;
    end else if (adv) begin
      mp_valid <= vv[NS];
    end
    if (adv) begin
      mp_mag <= m_val * $signed({1'b0, INV_GAIN_Q30});
      mp_gnd <= z_fin * $signed({1'b0, radius});
    end
  end

  // Round, subtract the radius and saturate.
  logic signed [65:0]         p_full, h_full;
  logic signed [57:0]         g_full;
  logic signed [HEIGHT_W-1:0] h_sat;
  logic        [GROUND_W-1:0] g_sat;

  always_comb begin
    p_full = mp_mag - $signed(66'(radius) << 38);
    h_full = (p_full + 66'sh20_0000_0000) >>> 38;
    g_full = (mp_gnd + 58'sh2000_0000) >>> 30;
    if (h_full > 66'sd1048575) begin
      h_sat = {1'b0, {(HEIGHT_W-1){1'b1}}};
    end else if (h_full < -66'sd1048576) begin
      h_sat = {1'b1, {(HEIGHT_W-1){1'b0}}};
    end else begin
      h_sat = h_full[HEIGHT_W-1:0];
    end
    if (g_full < 0) begin
      g_sat = '0;
    end else if (g_full > 58'sd1048575) begin
      g_sat = '1;
    end else begin
      g_sat = g_full[GROUND_W-1:0];
    end
  end

  logic                       o_valid;
  logic signed [HEIGHT_W-1:0] o_height;
  logic        [GROUND_W-1:0] o_ground;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= mp_valid;
    end
    if (adv) begin
      o_height <= h_sat;
      o_ground <= g_sat;
    end
  end

  // Skid register: catches the output word when the receiver stalls while
  // the pipeline moves on. It always holds the older of the two words.
  logic signed [HEIGHT_W-1:0] skid_height;
  logic        [GROUND_W-1:0] skid_ground;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_ch.ready) begin
        skid_full <= 1'b0;
      end
    end else if (o_valid && !out_ch.ready) begin
      skid_full <= 1'b1;
    end
    if (!skid_full) begin
      skid_height <= o_height;
      skid_ground <= o_ground;
    end
  end

  assign out_ch.valid           = skid_full | o_valid;
  assign out_ch.height          = skid_full ? skid_height : o_height;
  assign out_ch.ground_distance = skid_full ? skid_ground : o_ground;

  // The skid register only fills from a stalled, valid output word.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(o_valid && !out_ch.ready))
    else $error("skid register filled without a stalled output word");

  // While the skid register is full the output stage holds its word.
  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    skid_full |=> $stable(o_valid) && (!o_valid || $stable(o_height)))
    else $error("output stage changed while the skid register was full");

  // An accepted input word always reaches the entry stage.
  a_entry: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> s0_valid)
    else $error("accepted input word missing from the entry stage");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rbh_pkg::*;

  // The angle format and the stage count match the block's defaults.
  localparam int ANGLE_FRAC = 16;
  localparam int STAGES     = 20;
  // Settle waits are rounded up from the pipeline depth.
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_BINS   = 1620;
  localparam int CHUNKS        = 6;

  localparam logic signed [ELEV_W-1:0] ELEV_MAX = 18'sd102944;
  localparam logic signed [ELEV_W-1:0] ELEV_MIN = -18'sd102944;
  localparam logic [RANGE_W-1:0]       RANGE_MAX = '1;
  localparam logic [RADIUS_W-1:0]      RADIUS_MAX = '1;

  typedef struct {
    logic signed [HEIGHT_W-1:0] height;
    logic        [GROUND_W-1:0] ground;
  } bin_geo_t;

  // One row of the directed table. When known is set, the expected word is
  // typed into the row instead of coming from the predictor.
  typedef struct {
    logic [RADIUS_W-1:0]        radius;
    logic signed [ELEV_W-1:0]   elev;
    logic [RANGE_W-1:0]         rng;
    bit                         known;
    logic signed [HEIGHT_W-1:0] height;
    logic        [GROUND_W-1:0] ground;
  } bin_row_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [RADIUS_W-1:0] cfg_wr_data;

  rbh_in_if  in_ch ();
  rbh_out_if out_ch ();

  radar_bin_height_and_ground dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source)
  );

  // Testbench copy of the radius register; it follows every write we make.
  logic [RADIUS_W-1:0] radius_shadow;
  bin_geo_t geo_pending[$];
  int  errors = 0;
  int  src_idle_pct;
  int  snk_idle_pct;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Height and ground distance of one bin, worked out with 64-bit integers
  // in the same Q30 angle and Q16 distance formats as the hardware.
  function automatic bin_geo_t predict_geo(input logic signed [ELEV_W-1:0] elev,
                                           input logic [RANGE_W-1:0] rng,
                                           input logic [RADIUS_W-1:0] radius);
    bin_geo_t res;
    longint a, z, x, y, u, v, dx, dy, m, p, h, t, g, tab;
    bit flip;
    a = longint'(radius);
    flip = 1'b0;
    z = longint'(elev) * (longint'(1) <<< (30 - ANGLE_FRAC));
    // Fold the beam angle into [-pi/2, pi/2]; every fold negates the vector.
    while (z > longint'(HALF_PI_Q30)) begin
      z -= longint'(PI_Q30);
      flip = !flip;
    end
    while (z < -longint'(HALF_PI_Q30)) begin
      z += longint'(PI_Q30);
      flip = !flip;
    end
    // Rotation: the range, pre-scaled by the inverse CORDIC gain, turned by eta.
    x = (longint'(rng) * longint'(INV_GAIN_Q30) + 64'sd8192) >>> 14;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      tab = longint'(atan_q30(i[4:0]));
      if (z >= 0) begin
        x -= dx; y += dy; z -= tab;
      end else begin
        x += dx; y -= dy; z += tab;
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    // Vectoring of (a + b sin, b cos): the magnitude and the ground angle.
    u = (a <<< 16) + y;
    v = x;
    if (u < 0) begin
      u = -u;
      v = -v;
    end
    z = 0;
    if (u != 0 || v != 0) begin
      for (int i = 0; i < STAGES; i++) begin
        dx = v >>> i;
        dy = u >>> i;
        tab = longint'(atan_q30(i[4:0]));
        if (v >= 0) begin
          u += dx; v -= dy; z += tab;
        end else begin
          u -= dx; v += dy; z -= tab;
        end
      end
    end
    m = u >>> 8;
    p = m * longint'(INV_GAIN_Q30) - (a <<< 38);
    h = (p + (longint'(1) <<< 37)) >>> 38;
    if (h > 1048575) h = 1048575;
    if (h < -1048576) h = -1048576;
    t = z * a;
    g = (t + (longint'(1) <<< 29)) >>> 30;
    if (g < 0) g = 0;
    if (g > 1048575) g = 1048575;
    res.height = h[HEIGHT_W-1:0];
    res.ground = g[GROUND_W-1:0];
    return res;
  endfunction

  // Offers one word on the input channel, idling first at random, and
  // records the expected result on the edge where the word is taken.
  task automatic send_bin(input logic signed [ELEV_W-1:0] elev,
                          input logic [RANGE_W-1:0] rng,
                          input bit known,
                          input bin_geo_t typed);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.elevation  <= elev;
    in_ch.beam_range <= rng;
    do @(posedge clk); while (!in_ch.ready);
    if (known) geo_pending.push_back(typed);
    else geo_pending.push_back(predict_geo(elev, rng, radius_shadow));
  endtask

  // The radius is only changed with the pipeline empty: wait for every
  // expected word, then wait out the settle time.
  task automatic write_radius(input logic [RADIUS_W-1:0] value);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (geo_pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en     <= 1'b0;
    radius_shadow  = value;
  endtask

  // The receiver stalls at random; its ready changes on the falling edge.
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Every word taken from the output is checked against the oldest expectation.
  always @(posedge clk) begin
    bin_geo_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (geo_pending.size() == 0) begin
        $error("unexpected output word: height %0d ground_distance %0d",
               out_ch.height, out_ch.ground_distance);
        errors++;
      end else begin
        want = geo_pending.pop_front();
        if (out_ch.height !== want.height) begin
          $error("height: expected %0d, got %0d", want.height, out_ch.height);
          errors++;
        end
        if (out_ch.ground_distance !== want.ground) begin
          $error("ground_distance: expected %0d, got %0d", want.ground,
                 out_ch.ground_distance);
          errors++;
        end
      end
    end
  end

  // Directed table: field extremes, folded angles, the zero vector, a zero
  // radius and the smallest and largest radius. Only the zero vector has an
  // expected word that is obvious without working the CORDIC through.
  bin_row_t directed_rows[] = '{
    '{RADIUS_RESET, 18'sd0,       20'd0,       1'b0, 21'sd0, 20'd0},
    '{RADIUS_RESET, 18'sd0,       RANGE_MAX,   1'b0, 21'sd0, 20'd0},
    '{RADIUS_RESET, ELEV_MAX,     RANGE_MAX,   1'b0, 21'sd0, 20'd0},
    '{RADIUS_RESET, ELEV_MIN,     RANGE_MAX,   1'b0, 21'sd0, 20'd0},
    '{RADIUS_RESET, 18'sd1,       20'd1000,    1'b0, 21'sd0, 20'd0},
    '{RADIUS_RESET, -18'sd1,      20'd1000,    1'b0, 21'sd0, 20'd0},
    '{RADIUS_RESET, 18'sd131071,  20'd50000,   1'b0, 21'sd0, 20'd0},
    '{RADIUS_RESET, -18'sd131072, 20'd50000,   1'b0, 21'sd0, 20'd0},
    '{RADIUS_RESET, 18'sd102943,  20'd1,       1'b0, 21'sd0, 20'd0},
    '{RADIUS_RESET, -18'sd34000,  RANGE_MAX,   1'b0, 21'sd0, 20'd0},
    '{24'd0,        18'sd0,       20'd0,       1'b1, 21'sd0, 20'd0},
    '{24'd0,        ELEV_MAX,     20'd0,       1'b1, 21'sd0, 20'd0},
    '{24'd0,        18'sd5000,    20'd123456,  1'b0, 21'sd0, 20'd0},
    '{24'd0,        ELEV_MIN,     RANGE_MAX,   1'b0, 21'sd0, 20'd0},
    '{24'd1,        18'sd0,       20'd0,       1'b0, 21'sd0, 20'd0},
    '{24'd1,        -18'sd60000,  20'd10,      1'b0, 21'sd0, 20'd0},
    '{24'd1,        ELEV_MAX,     RANGE_MAX,   1'b0, 21'sd0, 20'd0},
    '{RADIUS_MAX,   18'sd0,       RANGE_MAX,   1'b0, 21'sd0, 20'd0},
    '{RADIUS_MAX,   ELEV_MAX,     RANGE_MAX,   1'b0, 21'sd0, 20'd0},
    '{RADIUS_MAX,   ELEV_MIN,     RANGE_MAX,   1'b0, 21'sd0, 20'd0},
    '{RADIUS_MAX,   -18'sd131072, 20'd777,     1'b0, 21'sd0, 20'd0}
  };

  initial begin
    bin_geo_t typed;
    logic [RADIUS_W-1:0] chunk_radius;
    logic signed [ELEV_W-1:0] elev;
    logic [RANGE_W-1:0] rng;
    int sel;

    src_idle_pct = 30;
    snk_idle_pct = 86;
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_ch.valid      = 1'b0;
    in_ch.elevation  = '0;
    in_ch.beam_range = '0;
    radius_shadow    = RADIUS_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].radius !== radius_shadow)
        write_radius(directed_rows[r].radius);
      typed.height = directed_rows[r].height;
      typed.ground = directed_rows[r].ground;
      send_bin(directed_rows[r].elev, directed_rows[r].rng, directed_rows[r].known, typed);
    end

    // Random bins in chunks; each chunk may run under a fresh radius, and the
    // idle pattern moves from receiver-heavy to sender-heavy to none.
    for (int c = 0; c < CHUNKS; c++) begin
      case (c)
        0: chunk_radius = RADIUS_RESET;
        1: chunk_radius = RADIUS_W'($urandom_range(1000, 1 << 22));
        2: chunk_radius = RADIUS_MAX;
        3: chunk_radius = 24'd1;
        4: chunk_radius = RADIUS_W'($urandom());
        default: chunk_radius = RADIUS_RESET;
      endcase
      if (chunk_radius !== radius_shadow) write_radius(chunk_radius);
      src_idle_pct = (c < 2) ? 30 : (c < 4) ? 86 : 0;
      snk_idle_pct = (c < 2) ? 86 : (c < 4) ? 30 : 0;
      for (int k = 0; k < RANDOM_BINS / CHUNKS; k++) begin
        // Mostly real beam elevations, some near horizontal, some anything.
        sel = $urandom_range(99);
        if (sel < 70) elev = ELEV_W'($urandom_range(0, 2 * 102944) - 102944);
        else if (sel < 85) elev = ELEV_W'($urandom_range(0, 4000) - 2000);
        else elev = ELEV_W'($urandom());
        sel = $urandom_range(99);
        if (sel < 70) rng = RANGE_W'($urandom());
        else if (sel < 90) rng = RANGE_W'($urandom_range(0, 5000));
        else rng = (sel < 95) ? RANGE_MAX : 20'd0;
        send_bin(elev, rng, 1'b0, typed);
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (geo_pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("PASS radar_bin_height_and_ground");
    end else begin
      $display("FAIL radar_bin_height_and_ground");
    end
    $finish;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("FAIL radar_bin_height_and_ground");
    $finish;
  end

endmodule

// File: radar_bin_height_and_ground.f
sv/rbh_pkg.sv
sv/rbh_if.sv
sv/rbh_fold_stage.sv
sv/rbh_rot_stage.sv
sv/rbh_vec_stage.sv
sv/radar_bin_height_and_ground.sv
tb/tb_top.sv
